// ----- hdl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 stream cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

    localparam int DATA_W    = 8;
    localparam int KIDX_W    = 6;
    localparam int OP_W      = 2;
    localparam int PERM_AW   = 8;
    localparam int PERM_DEPTH = 256;
    localparam int KEY_LEN_W = 7;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 7'd16;
    localparam logic [PERM_AW-1:0]   PERM_LAST     = 8'hFF;
    localparam logic [CFG_AW-1:0]    ADDR_KEY_LENGTH = 3'd0;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_KEY_WRITE = 2'd0;
    localparam op_t OP_SCHEDULE  = 2'd1;
    localparam op_t OP_DATA      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_SWAP_N,
        ST_KS_SWAP_J,
        ST_DT_RDJ,
        ST_DT_SWAP,
        ST_DT_OUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [KIDX_W-1:0] key_index;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } res_t;

endpackage

`default_nettype wire

// ----- hdl/rc4_ram.sv -----
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// A read in the same cycle as a write to the same entry returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/rc4_engine.sv -----
// ----------------------------------------------------------------------------
// rc4_engine
// Sequencer around the permutation and key store RAMs: key writes, key
// schedule (identity fill, then key mix) and per-byte keystream generation.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_engine #(
    parameter int KEY_MAX = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire rc4_pkg::cmd_t                    cmd,
    input  wire logic [rc4_pkg::KEY_LEN_W-1:0]    key_len,
    input  wire logic                             res_ready,
    output logic                                  idle,
    output rc4_pkg::res_t                         res
);

    localparam int KW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KLW = 9;

    rc4_pkg::state_t state_reg, state_next;

    logic [rc4_pkg::PERM_AW-1:0] i_reg, i_next;
    logic [rc4_pkg::PERM_AW-1:0] j_reg, j_next;
    logic [KW-1:0]               kpos_reg, kpos_next;
    logic [rc4_pkg::DATA_W-1:0]  sa_reg, sa_next;
    logic [rc4_pkg::DATA_W-1:0]  sb_reg, sb_next;
    logic [rc4_pkg::DATA_W-1:0]  val_reg, val_next;

    logic                        pw_en, pr_en;
    logic [rc4_pkg::PERM_AW-1:0] pw_addr, pr_addr;
    logic [rc4_pkg::DATA_W-1:0]  pw_data, p_rdata;
    logic                        kw_en, kr_en;
    logic [KW-1:0]               kw_addr, kr_addr;
    logic [rc4_pkg::DATA_W-1:0]  k_rdata;

    logic [KLW-1:0]              klen_raw, klen;
    logic [KLW-1:0]              kpos_inc;
    logic [rc4_pkg::PERM_AW-1:0] jsum;
    logic [rc4_pkg::PERM_AW-1:0] t_addr;
    logic [rc4_pkg::DATA_W-1:0]  st_val;
    logic                        key_in_range;

    // Clamp key length to 1..KEY_MAX
    always_comb begin
        klen_raw = (key_len == '0) ? KLW'(1) : KLW'(key_len);
        klen     = (klen_raw > KLW'(KEY_MAX)) ? KLW'(KEY_MAX) : klen_raw;
    end

    assign kpos_inc     = KLW'(kpos_reg) + KLW'(1);
    assign key_in_range = (KLW'(cmd.key_index) < KLW'(KEY_MAX));
    assign t_addr       = sa_reg + sb_reg;

    // Keystream entry: forward the two swapped entries, the RAM read was old
    always_comb begin
        if (t_addr == j_reg) begin
            st_val = sa_reg;
        end else if (t_addr == i_reg) begin
            st_val = sb_reg;
        end else begin
            st_val = p_rdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rc4_pkg::ST_IDLE: begin
                if (start) begin
                    case (cmd.op)
                        rc4_pkg::OP_SCHEDULE: state_next = rc4_pkg::ST_FILL;
                        rc4_pkg::OP_DATA:     state_next = rc4_pkg::ST_DT_RDJ;
                        default:              state_next = rc4_pkg::ST_IDLE;
                    endcase
                end
            end
            rc4_pkg::ST_FILL: begin
                if (i_reg == rc4_pkg::PERM_LAST) begin
                    state_next = rc4_pkg::ST_KS_RD;
                end
            end
            rc4_pkg::ST_KS_RD:     state_next = rc4_pkg::ST_KS_J;
            rc4_pkg::ST_KS_J:      state_next = rc4_pkg::ST_KS_SWAP_N;
            rc4_pkg::ST_KS_SWAP_N: state_next = rc4_pkg::ST_KS_SWAP_J;
            rc4_pkg::ST_KS_SWAP_J: begin
                state_next = (i_reg == rc4_pkg::PERM_LAST) ? rc4_pkg::ST_IDLE
                                                           : rc4_pkg::ST_KS_RD;
            end
            rc4_pkg::ST_DT_RDJ:    state_next = rc4_pkg::ST_DT_SWAP;
            rc4_pkg::ST_DT_SWAP:   state_next = rc4_pkg::ST_DT_OUT;
            rc4_pkg::ST_DT_OUT: begin
                if (res_ready) begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pw_en     = 1'b0;
        pw_addr   = i_reg;
        pw_data   = '0;
        pr_en     = 1'b0;
        pr_addr   = i_reg;
        kw_en     = 1'b0;
        kw_addr   = KW'(cmd.key_index);
        kr_en     = 1'b0;
        kr_addr   = kpos_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        kpos_next = kpos_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        val_next  = val_reg;
        jsum      = '0;
        res.valid = 1'b0;
        res.data  = val_reg ^ st_val;
        unique case (state_reg)
            rc4_pkg::ST_IDLE: begin
                if (start) begin
                    val_next = cmd.value;
                    case (cmd.op)
                        rc4_pkg::OP_KEY_WRITE: kw_en = key_in_range;
                        rc4_pkg::OP_SCHEDULE:  i_next = '0;
                        rc4_pkg::OP_DATA: begin
                            i_next  = i_reg + 1'b1;
                            pr_en   = 1'b1;
                            pr_addr = i_reg + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            rc4_pkg::ST_FILL: begin
                pw_en   = 1'b1;
                pw_data = i_reg;
                i_next  = i_reg + 1'b1;
                if (i_reg == rc4_pkg::PERM_LAST) begin
                    j_next    = '0;
                    kpos_next = '0;
                end
            end
            rc4_pkg::ST_KS_RD: begin
                pr_en = 1'b1;
                kr_en = 1'b1;
            end
            rc4_pkg::ST_KS_J: begin
                jsum    = j_reg + p_rdata + k_rdata;
                j_next  = jsum;
                sa_next = p_rdata;
                pr_en   = 1'b1;
                pr_addr = jsum;
            end
            rc4_pkg::ST_KS_SWAP_N: begin
                pw_en   = 1'b1;
                pw_data = p_rdata;
            end
            rc4_pkg::ST_KS_SWAP_J: begin
                pw_en     = 1'b1;
                pw_addr   = j_reg;
                pw_data   = sa_reg;
                i_next    = i_reg + 1'b1;
                kpos_next = (kpos_inc >= klen) ? '0 : KW'(kpos_inc);
                if (i_reg == rc4_pkg::PERM_LAST) begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            rc4_pkg::ST_DT_RDJ: begin
                jsum    = j_reg + p_rdata;
                j_next  = jsum;
                sa_next = p_rdata;
                pr_en   = 1'b1;
                pr_addr = jsum;
            end
            rc4_pkg::ST_DT_SWAP: begin
                pw_en   = 1'b1;
                pw_data = p_rdata;
                sb_next = p_rdata;
                pr_en   = 1'b1;
                pr_addr = sa_reg + p_rdata;
            end
            rc4_pkg::ST_DT_OUT: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    pw_en   = 1'b1;
                    pw_addr = j_reg;
                    pw_data = sa_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rc4_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            kpos_reg  <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            kpos_reg  <= kpos_next;
        end
    end

    always_ff @(posedge aclk) begin
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        val_reg <= val_next;
    end

    assign idle = (state_reg == rc4_pkg::ST_IDLE);

    rc4_ram #(
        .WIDTH (rc4_pkg::DATA_W),
        .DEPTH (rc4_pkg::PERM_DEPTH),
        .AW    (rc4_pkg::PERM_AW)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (pw_en),
        .waddr (pw_addr),
        .wdata (pw_data),
        .re    (pr_en),
        .raddr (pr_addr),
        .rdata (p_rdata)
    );

    rc4_ram #(
        .WIDTH (rc4_pkg::DATA_W),
        .DEPTH (KEY_MAX),
        .AW    (KW)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (kw_en),
        .waddr (kw_addr),
        .wdata (cmd.value),
        .re    (kr_en),
        .raddr (kr_addr),
        .rdata (k_rdata)
    );

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == rc4_pkg::ST_IDLE))
        else $error("command started while engine busy");

    a_sched_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4_pkg::ST_KS_SWAP_J && i_reg == rc4_pkg::PERM_LAST)
        |=> (state_reg == rc4_pkg::ST_IDLE && i_reg == '0 && j_reg == '0))
        else $error("key schedule did not end with cleared indices");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4_pkg::ST_DT_OUT && !res_ready)
        |=> (state_reg == rc4_pkg::ST_DT_OUT && $stable(res.data)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- hdl/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine with streaming command input, streaming byte output and an
// APB register for the key length.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  s_        | in        | s_tvalid/s_tready  | tuser op, tdata key_index,value
//  m_        | out       | m_tvalid/m_tready  | tdata out_byte
//  apb       | in/out    | psel/penable/pready| key_length at byte address 0
//
// A data byte runs in steps set by the single read port of the permutation
// RAM (read i, read j, read keystream entry, final write-back). Key schedule:
// 256 identity fill writes, then a read, j update and two swap writes per mix
// step. Reset clears indices, the key length (to 16) and the output valid flag;
// the permutation holds no defined contents until a schedule runs. An output
// stall holds the engine in its last data step; the engine returns to idle
// and takes a new item once the result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
    parameter int KEY_MAX = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // slave stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [5:0] key_index, [13:6] value
    input  wire logic [rc4_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    // master stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rc4_pkg::DATA_W-1:0]         m_tdata,   // [7:0] out_byte
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rc4_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [rc4_pkg::CFG_DW-1:0]    pwdata,
    output logic      [rc4_pkg::CFG_DW-1:0]    prdata,
    output logic                               pready
);

    logic [rc4_pkg::KEY_LEN_W-1:0] key_length_reg, key_length_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [rc4_pkg::DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic           eng_idle;
    logic           eng_start;
    logic           res_ready;
    rc4_pkg::cmd_t  eng_cmd;
    rc4_pkg::res_t  eng_res;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == rc4_pkg::ADDR_KEY_LENGTH);

    always_comb begin
        key_length_next = key_length_reg;
        if (cfg_wr) begin
            key_length_next = pwdata[rc4_pkg::KEY_LEN_W-1:0];
        end
    end

    always_comb begin
        if (paddr == rc4_pkg::ADDR_KEY_LENGTH) begin
            prdata = rc4_pkg::CFG_DW'(key_length_reg);
        end else begin
            prdata = '0;
        end
    end

    assign s_tready  = eng_idle;
    assign eng_start = s_tvalid && s_tready;

    always_comb begin
        eng_cmd.op        = s_tuser;
        eng_cmd.key_index = s_tdata[5:0];
        eng_cmd.value     = s_tdata[13:6];
    end

    // Output register: free when empty or drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = eng_res.valid;
            if (eng_res.valid) begin
                m_tdata_next = eng_res.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= rc4_pkg::KEY_LEN_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            key_length_reg <= key_length_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rc4_engine #(
        .KEY_MAX (KEY_MAX)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .cmd       (eng_cmd),
        .key_len   (key_length_reg),
        .res_ready (res_ready),
        .idle      (eng_idle),
        .res       (eng_res)
    );

    a_res_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_res.valid && res_ready) |=> m_tvalid_reg)
        else $error("engine result dropped");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rc4_stream_cipher. Key bytes, schedule commands and
// data bytes go in over the s_ stream, and the key length is set over APB.
// A keystream predictor tracks the permutation, the key store and both
// indices. Every byte on the m_ stream is compared with the oldest predicted
// cipher byte. Both streams idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int           KEY_SLOTS    = 64;
    localparam rc4_pkg::op_t OP_UNUSED    = 2'd3;
    localparam int           RANDOM_ITEMS = 1250;
    localparam int           QUIET_CYCLES = 1400;
    localparam int unsigned  CYCLE_LIMIT  = 1000000;

    // ------------------------------------------------------------------------
    // Keystream predictor and store of expected cipher bytes
    // ------------------------------------------------------------------------
    class rc4_keystream_model;
        logic [7:0] sbox [rc4_pkg::PERM_DEPTH];
        logic [7:0] key_bytes [KEY_SLOTS];
        logic [7:0] idx_i;
        logic [7:0] idx_j;
        logic [rc4_pkg::KEY_LEN_W-1:0] key_len;
        logic [7:0] cipher_bytes [$];
        int mismatches;
        int bytes_checked;
        int key_writes;
        int schedules;
        int ignored_items;

        function new();
            for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) sbox[n] = 8'h00;
            for (int n = 0; n < KEY_SLOTS; n++) key_bytes[n] = 8'h00;
            idx_i = 8'h00;
            idx_j = 8'h00;
            key_len = rc4_pkg::KEY_LEN_RESET;
            mismatches = 0;
            bytes_checked = 0;
            key_writes = 0;
            schedules = 0;
            ignored_items = 0;
        endfunction

        function void set_key_length(logic [31:0] v);
            key_len = v[rc4_pkg::KEY_LEN_W-1:0];
        endfunction

        // Clamp the register into 1..KEY_SLOTS.
        function int unsigned mix_length();
            int unsigned n;
            n = {25'd0, key_len};
            if (n == 0) n = 1;
            if (n > KEY_SLOTS) n = KEY_SLOTS;
            return n;
        endfunction

        function void run_key_mix();
            int unsigned klen;
            logic [7:0] jj;
            logic [7:0] t;
            klen = mix_length();
            for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) sbox[n] = n[7:0];
            jj = 8'h00;
            for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
                jj = jj + sbox[n] + key_bytes[n % klen];
                t = sbox[n];
                sbox[n] = sbox[jj];
                sbox[jj] = t;
            end
            idx_i = 8'h00;
            idx_j = 8'h00;
        endfunction

        function void note_item(rc4_pkg::op_t op, logic [rc4_pkg::KIDX_W-1:0] kidx,
                                logic [7:0] val);
            logic [7:0] t;
            case (op)
                rc4_pkg::OP_KEY_WRITE: begin
                    key_bytes[kidx] = val;
                    key_writes++;
                end
                rc4_pkg::OP_SCHEDULE: begin
                    run_key_mix();
                    schedules++;
                end
                rc4_pkg::OP_DATA: begin
                    idx_i = idx_i + 8'd1;
                    idx_j = idx_j + sbox[idx_i];
                    t = sbox[idx_i];
                    sbox[idx_i] = sbox[idx_j];
                    sbox[idx_j] = t;
                    t = sbox[idx_i] + sbox[idx_j];
                    cipher_bytes.push_back(val ^ sbox[t]);
                end
                default: begin
                    ignored_items++;
                end
            endcase
        endfunction

        function void check_byte(logic [7:0] got);
            logic [7:0] want;
            if (cipher_bytes.size() == 0) begin
                $error("out_byte: unexpected beat, actual %02h", got);
                mismatches++;
                return;
            end
            want = cipher_bytes.pop_front();
            bytes_checked++;
            if (got !== want) begin
                $error("out_byte mismatch: expected %02h, actual %02h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;   // [5:0] key_index, [13:6] value
    logic [rc4_pkg::OP_W-1:0]      s_tuser;   // [1:0] operation
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rc4_pkg::DATA_W-1:0]    m_tdata;   // [7:0] out_byte
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rc4_pkg::CFG_AW-1:0]    paddr;
    logic [rc4_pkg::CFG_DW-1:0]    pwdata;
    logic [rc4_pkg::CFG_DW-1:0]    prdata;
    logic                          pready;

    rc4_stream_cipher #(.KEY_MAX(KEY_SLOTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rc4_keystream_model model;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int unsigned cycle_count    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Track accepted beats on both streams.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_tvalid && s_tready)
            model.note_item(s_tuser, s_tdata[5:0], s_tdata[13:6]);
        if (aresetn === 1'b1 && m_tvalid && m_tready)
            model.check_byte(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input rc4_pkg::op_t op,
                             input logic [rc4_pkg::KIDX_W-1:0] kidx,
                             input logic [7:0] val);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, val, kidx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Hold off the sender until every predicted byte has come out.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (model.cipher_bytes.size() > 0) @(posedge aclk);
    endtask

    // Drain, then give a trailing schedule time to finish.
    task automatic settle();
        drain();
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_length(input logic [31:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rc4_pkg::ADDR_KEY_LENGTH;
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        model.set_key_length(v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(input int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned extremes [7];
        int          phase;
        int unsigned klen;
        int unsigned eff;
        int unsigned n_data;
        int unsigned roll;

        extremes = '{127, 1, 64, 65, 0, 10, 16};
        model    = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero key length (runs as one byte), field extremes,
        // unused operation, key write and re-key in the middle of a stream.
        write_key_length(32'd0);
        send_item(rc4_pkg::OP_KEY_WRITE, 6'd0, 8'hFF);
        send_item(rc4_pkg::OP_KEY_WRITE, 6'd63, 8'h00);
        send_item(OP_UNUSED, 6'h3F, 8'hFF);
        send_item(rc4_pkg::OP_SCHEDULE, 6'h00, 8'h00);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'h00);
        send_item(rc4_pkg::OP_DATA, 6'h3F, 8'hFF);
        send_item(rc4_pkg::OP_DATA, 6'h2A, 8'h5A);
        send_item(rc4_pkg::OP_DATA, 6'h15, 8'hA5);
        send_item(OP_UNUSED, 6'h00, 8'h00);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'h01);
        send_item(rc4_pkg::OP_KEY_WRITE, 6'd1, 8'h3C);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'h80);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'h7F);
        send_item(rc4_pkg::OP_KEY_WRITE, 6'd0, 8'h00);
        send_item(rc4_pkg::OP_SCHEDULE, 6'h3F, 8'hFF);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'h00);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'h00);
        send_item(rc4_pkg::OP_DATA, 6'h00, 8'hFF);

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            set_mode(phase);
            settle();
            if (phase < 7) begin
                klen = extremes[phase];
            end else if ($urandom_range(0, 4) == 0) begin
                klen = $urandom_range(0, 127);
            end else begin
                klen = $urandom_range(1, 64);
            end
            write_key_length(($urandom() & 32'hFFFF_FF80) | klen);
            eff = (klen == 0) ? 1 : (klen > KEY_SLOTS) ? KEY_SLOTS : klen;

            // Fill the whole store once so that every later mix reads
            // defined bytes.
            if (phase == 0) begin
                for (int k = 0; k < KEY_SLOTS; k++)
                    send_item(rc4_pkg::OP_KEY_WRITE, 6'(k), 8'($urandom_range(0, 255)));
            end
            if (eff > 10 && $urandom_range(0, 1) == 1) begin
                // Fresh ten-byte IV at the tail of the key.
                for (int k = eff - 10; k < eff; k++)
                    send_item(rc4_pkg::OP_KEY_WRITE, 6'(k), 8'($urandom_range(0, 255)));
            end
            for (int k = $urandom_range(0, 8); k > 0; k--)
                send_item(rc4_pkg::OP_KEY_WRITE, 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
            send_item(rc4_pkg::OP_SCHEDULE, 6'($urandom_range(0, 63)),
                      8'($urandom_range(0, 255)));

            n_data = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(10, 70);
            for (int k = 0; k < n_data; k++) begin
                if (phase % 5 == 2 && k == n_data / 2) drain();
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    send_item(OP_UNUSED, 6'($urandom_range(0, 63)),
                              8'($urandom_range(0, 255)));
                else if (roll < 10)
                    send_item(rc4_pkg::OP_KEY_WRITE, 6'($urandom_range(0, 63)),
                              8'($urandom_range(0, 255)));
                else if (roll < 12)
                    send_item(rc4_pkg::OP_SCHEDULE, 6'($urandom_range(0, 63)),
                              8'($urandom_range(0, 255)));
                else
                    send_item(rc4_pkg::OP_DATA, 6'($urandom_range(0, 63)),
                              8'($urandom_range(0, 255)));
            end
            phase++;
        end

        set_mode(2);
        settle();
        if (model.cipher_bytes.size() != 0) begin
            $error("out_byte: %0d expected beats never arrived", model.cipher_bytes.size());
            model.mismatches++;
        end

        $display("Ran %0d phases: %0d key schedules, %0d key writes, %0d ignored items,",
                 phase, model.schedules, model.key_writes, model.ignored_items);
        $display("and checked %0d cipher bytes; %0d mismatches.",
                 model.bytes_checked, model.mismatches);
        if (model.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
